/* rtl/core/hsg_pkg.sv */
// Shared types, constants and arithmetic helpers of the hex8 shape gradient block.
package hsg_pkg;

  // Shift codes for the shared multiplier.
  localparam logic [1:0] SH_J = 2'd0;   // shift by 30 (Q30 operand)
  localparam logic [1:0] SH_Q = 2'd1;   // shift by the fraction width
  localparam logic [1:0] SH_G = 2'd2;   // shift by 62 minus the fraction width

  localparam logic [63:0] GQ30   = 64'd619925131;
  localparam logic [63:0] ONEQ30 = 64'd1 << 30;
  localparam logic [63:0] AP     = ONEQ30 + GQ30;
  localparam logic [63:0] AM     = ONEQ30 - GQ30;
  localparam logic [63:0] MAG2   = (AP * AP) >> 33;
  localparam logic [63:0] MAG1   = (AP * AM) >> 33;
  localparam logic [63:0] MAG0   = (AM * AM) >> 33;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic       start;
    logic [1:0] shift;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Saturating 64-bit add or subtract.
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input logic sub);
    logic [64:0] s;
    s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  // Sign bit of a node or point along a parent direction: 1 means plus.
  function automatic logic pbit(input logic [2:0] i, input logic [1:0] d);
    logic r;
    case (d)
      2'd0:    r = i[0] ^ i[1];
      2'd1:    r = i[1];
      default: r = i[2];
    endcase
    return r;
  endfunction

  // Parent-domain shape derivative in Q30 of node n along direction b at point gp.
  function automatic logic signed [63:0] dparent(input logic [1:0] b, input logic [2:0] n,
                                                 input logic [2:0] gp);
    logic [1:0]  cnt;
    logic [63:0] m;
    cnt = 2'd0;
    for (int k = 0; k < 3; k++) begin
      if ((2'(k) != b) && (pbit(n, 2'(k)) == pbit(gp, 2'(k)))) begin
        cnt = cnt + 2'd1;
      end
    end
    case (cnt)
      2'd0:    m = MAG0;
      2'd1:    m = MAG1;
      default: m = MAG2;
    endcase
    return pbit(n, b) ? m : -m;
  endfunction

  // Operand indexes of the adjugate and determinant products.
  // J entries sit at 0..8 (row*3+col), adjugate entries at 9..17.
  function automatic logic [4:0] op_idx(input logic [4:0] step, input logic second);
    logic [9:0] p;
    case (step)
      5'd0:  p = {5'd4, 5'd8};
      5'd1:  p = {5'd5, 5'd7};
      5'd2:  p = {5'd2, 5'd7};
      5'd3:  p = {5'd1, 5'd8};
      5'd4:  p = {5'd1, 5'd5};
      5'd5:  p = {5'd2, 5'd4};
      5'd6:  p = {5'd5, 5'd6};
      5'd7:  p = {5'd3, 5'd8};
      5'd8:  p = {5'd0, 5'd8};
      5'd9:  p = {5'd2, 5'd6};
      5'd10: p = {5'd2, 5'd3};
      5'd11: p = {5'd0, 5'd5};
      5'd12: p = {5'd3, 5'd7};
      5'd13: p = {5'd4, 5'd6};
      5'd14: p = {5'd1, 5'd6};
      5'd15: p = {5'd0, 5'd7};
      5'd16: p = {5'd0, 5'd4};
      5'd17: p = {5'd1, 5'd3};
      5'd18: p = {5'd0, 5'd9};
      5'd19: p = {5'd1, 5'd12};
      5'd20: p = {5'd2, 5'd15};
      default: p = '0;
    endcase
    return second ? p[4:0] : p[9:5];
  endfunction

endpackage

/* rtl/core/hsg_if.sv */
// Valid/ready channel interfaces for node requests and gradient results.
interface hsg_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             gauss_point;
  logic [2:0]             node_index;
  logic [COORD_WIDTH-1:0] node_x;
  logic [COORD_WIDTH-1:0] node_y;
  logic [COORD_WIDTH-1:0] node_z;

  modport source (output valid, gauss_point, node_index, node_x, node_y, node_z,
                  input ready);
  modport sink (input valid, gauss_point, node_index, node_x, node_y, node_z,
                output ready);
endinterface

interface hsg_out_if #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             out_node;
  logic [COORD_WIDTH-1:0] grad_x;
  logic [COORD_WIDTH-1:0] grad_y;
  logic [COORD_WIDTH-1:0] grad_z;
  logic [COORD_WIDTH-1:0] jacobian_det;
  logic [FRAC_BITS:0]     point_weight;
  logic                   singular;
  logic                   last;

  modport source (output valid, out_node, grad_x, grad_y, grad_z, jacobian_det,
                  point_weight, singular, last, input ready);
  modport sink (input valid, out_node, grad_x, grad_y, grad_z, jacobian_det,
                point_weight, singular, last, output ready);
endinterface

/* rtl/core/hsg_mul.sv */
// Shared 64x64 signed multiplier: four 32x32 partial products, shift, saturate.
module hsg_mul
  import hsg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mul_req_t            req_i,
  input  logic signed [63:0]  op_a_i,
  input  logic signed [63:0]  op_b_i,
  output unit_stat_t          stat_o,
  output logic signed [63:0]  res_o
);

  logic [63:0]  ua_q, ub_q;
  logic         neg_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q, acc_d;
  logic [2:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, done_q, done_d;
  logic signed [63:0] res_q, res_d;

  logic [63:0]  pp;
  logic [6:0]   pp_sh;
  logic [127:0] mag;
  logic signed [127:0] sv;

  assign pp    = 64'(ua_q[cnt_q[1]*32 +: 32]) * 64'(ub_q[cnt_q[0]*32 +: 32]);
  assign pp_sh = 7'(({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]})) << 5;
  assign mag   = neg_q ? (~acc_q + 128'd1) : acc_q;

  always_comb begin
    case (sh_q)
      SH_Q:    sv = $signed(mag) >>> FRAC_BITS;
      SH_G:    sv = $signed(mag) >>> (62 - FRAC_BITS);
      default: sv = $signed(mag) >>> 30;
    endcase
  end

  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    res_d  = res_q;
    if (req_i.start) begin
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == 3'd4) begin
        // keep the value when the top 65 bits agree, else clamp
        if ((&sv[127:63]) || !(|sv[127:63])) begin
          res_d = sv[63:0];
        end else begin
          res_d = sv[127] ? S64_MIN : S64_MAX;
        end
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        acc_d = acc_q + ({64'd0, pp} << pp_sh);
        cnt_d = cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    res_q <= res_d;
    if (req_i.start) begin
      ua_q  <= op_a_i[63] ? (64'd0 - op_a_i) : op_a_i;
      ub_q  <= op_b_i[63] ? (64'd0 - op_b_i) : op_b_i;
      neg_q <= op_a_i[63] ^ op_b_i[63];
      sh_q  <= req_i.shift;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/hsg_div.sv */
// Restoring divider for the reciprocal 2^62 / |det|, one quotient bit per cycle.
module hsg_div
  import hsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] divisor_i,
  output unit_stat_t  stat_o,
  output logic [63:0] quot_o
);

  logic [63:0] d_q;
  logic [63:0] rem_q, rem_d;
  logic [62:0] quot_q, quot_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] r2;
  logic        ge;

  // dividend has only bit 62 set
  assign r2 = {rem_q, (cnt_q == 6'd62)};
  assign ge = r2 >= {1'b0, d_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = 6'd62;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? 64'(r2 - {1'b0, d_q}) : r2[63:0];
      quot_d = {quot_q[61:0], ge};
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      d_q <= divisor_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = {1'b0, quot_q};

endmodule

/* rtl/core/hex8_shape_gradient.sv */
// Top level: node coordinate store, sequencer and shared units of the hex8 gradient block.
//
// Usage: in_i carries one node request per handshake (gauss_point, node_index, node_x/y/z).
// Requests for nodes 0..6 only write the coordinate store and leave the sequencer idle.
// A request for node 7 writes its coordinates and starts the element compute at the
// gauss_point it carries; in_i.ready stays low until all eight results have been
// handed to the output register.
// out_o delivers eight results, nodes 0..7 in order, last set on node 7, each with
// the saturated spatial gradient, the determinant, weight 1.0 and the singular flag.
// A node 0..6 request is taken whenever the sequencer is idle. A node 7 request on a
// nonsingular element costs 189 passes through the shared 64x64 multiplier (each pass:
// four partial products, a shift and saturate, sequencing) and one run of the bit-serial
// reciprocal divider. A singular element skips the divider and the gradient passes.
// A stalled receiver holds the output register; the sequencer waits for it before
// loading the next node's result and does not lose or repeat any result.
// Reset clears the sequencer and the output valid; the coordinate store is undefined
// until each node has been written once.
module hex8_shape_gradient
  import hsg_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  hsg_in_if.sink     in_i,
  hsg_out_if.source  out_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_J_RD  = 4'd1;
  localparam logic [3:0] S_J_WT  = 4'd2;
  localparam logic [3:0] S_P_RDA = 4'd3;
  localparam logic [3:0] S_P_RDB = 4'd4;
  localparam logic [3:0] S_P_WT  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DV_WT = 4'd7;
  localparam logic [3:0] S_G_RDA = 4'd8;
  localparam logic [3:0] S_G_WT  = 4'd9;
  localparam logic [3:0] S_G_FIN = 4'd10;
  localparam logic [3:0] S_G_FWT = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  localparam int CW = COORD_WIDTH;

  logic [3:0] state_q, state_d;
  logic [2:0] gp_q, gp_d;
  logic [1:0] ca_q, ca_d;
  logic [1:0] cb_q, cb_d;
  logic [2:0] cn_q, cn_d;
  logic [4:0] step_q, step_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] t_q, t_d;
  logic signed [63:0] opa_q, opa_d;
  logic signed [63:0] det_q, det_d;
  logic signed [63:0] rs_q, rs_d;
  logic sing_q, sing_d;
  logic [CW-1:0] g_q [3];
  logic [CW-1:0] g_d [3];

  logic [CW-1:0] cx_q [8];
  logic [CW-1:0] cy_q [8];
  logic [CW-1:0] cz_q [8];
  logic signed [63:0] jr_q [18];
  logic        jr_we;
  logic [4:0]  jr_widx;
  logic signed [63:0] jr_wdata;
  logic [4:0]  rd_idx;
  logic signed [63:0] rd_data;

  logic          out_valid_q, out_valid_d, out_load;
  logic [2:0]    o_node_q;
  logic [CW-1:0] o_gx_q, o_gy_q, o_gz_q, o_det_q;
  logic          o_sing_q, o_last_q;

  mul_req_t           mreq;
  unit_stat_t         mstat, dstat;
  logic signed [63:0] mul_a, mul_b, mul_res;
  logic               div_start;
  logic [63:0]        div_d, div_q;
  logic signed [63:0] coord_sel, acc_sum, det_sum;

  function automatic logic [CW-1:0] sat_cw(input logic signed [63:0] v);
    if ((&v[63:CW-1]) || !(|v[63:CW-1])) begin
      return v[CW-1:0];
    end
    return v[63] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic logic signed [63:0] sext(input logic [CW-1:0] v);
    return {{(64-CW){v[CW-1]}}, v};
  endfunction

  hsg_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .stat_o (mstat),
    .res_o  (mul_res)
  );

  hsg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (div_d),
    .stat_o    (dstat),
    .quot_o    (div_q)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign rd_data    = jr_q[rd_idx];
  assign acc_sum    = sat_add(acc_q, mul_res, 1'b0);
  assign det_sum    = acc_sum;
  assign div_d      = det_q[63] ? (64'd0 - det_q) : det_q;
  assign div_start  = (state_q == S_DIV);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    case (ca_q)
      2'd0:    coord_sel = sext(cx_q[cn_q]);
      2'd1:    coord_sel = sext(cy_q[cn_q]);
      default: coord_sel = sext(cz_q[cn_q]);
    endcase
  end

  // operand routing into the shared multiplier and the single read port
  always_comb begin
    mreq   = '0;
    mul_a  = '0;
    mul_b  = '0;
    rd_idx = op_idx(step_q, 1'b0);
    unique case (state_q)
      S_J_RD: begin
        mreq.start = 1'b1;
        mreq.shift = SH_J;
        mul_a      = coord_sel;
        mul_b      = dparent(cb_q, cn_q, gp_q);
      end
      S_P_RDB: begin
        rd_idx     = op_idx(step_q, 1'b1);
        mreq.start = 1'b1;
        mreq.shift = SH_Q;
        mul_a      = opa_q;
        mul_b      = rd_data;
      end
      S_G_RDA: begin
        rd_idx     = 5'd9 + 5'(cb_q) * 5'd3 + 5'(ca_q);
        mreq.start = !sing_q;
        mreq.shift = SH_J;
        mul_a      = rd_data;
        mul_b      = dparent(cb_q, cn_q, gp_q);
      end
      S_G_FIN: begin
        mreq.start = 1'b1;
        mreq.shift = SH_G;
        mul_a      = acc_q;
        mul_b      = rs_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    gp_d     = gp_q;
    ca_d     = ca_q;
    cb_d     = cb_q;
    cn_d     = cn_q;
    step_d   = step_q;
    acc_d    = acc_q;
    t_d      = t_q;
    opa_d    = opa_q;
    det_d    = det_q;
    rs_d     = rs_q;
    sing_d   = sing_q;
    g_d      = g_q;
    jr_we    = 1'b0;
    jr_widx  = '0;
    jr_wdata = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid && (in_i.node_index == 3'd7)) begin
          gp_d    = in_i.gauss_point;
          ca_d    = '0;
          cb_d    = '0;
          cn_d    = '0;
          acc_d   = '0;
          state_d = S_J_RD;
        end
      end
      S_J_RD: state_d = S_J_WT;
      S_J_WT: begin
        if (mstat.done) begin
          state_d = S_J_RD;
          if (cn_q == 3'd7) begin
            jr_we    = 1'b1;
            jr_widx  = 5'(ca_q) * 5'd3 + 5'(cb_q);
            jr_wdata = acc_sum;
            acc_d    = '0;
            cn_d     = '0;
            if (cb_q == 2'd2) begin
              cb_d = '0;
              if (ca_q == 2'd2) begin
                step_d  = '0;
                state_d = S_P_RDA;
              end else begin
                ca_d = ca_q + 2'd1;
              end
            end else begin
              cb_d = cb_q + 2'd1;
            end
          end else begin
            acc_d = acc_sum;
            cn_d  = cn_q + 3'd1;
          end
        end
      end
      S_P_RDA: begin
        opa_d   = rd_data;
        state_d = S_P_RDB;
      end
      S_P_RDB: state_d = S_P_WT;
      S_P_WT: begin
        if (mstat.done) begin
          state_d = S_P_RDA;
          step_d  = step_q + 5'd1;
          if (step_q < 5'd18) begin
            if (!step_q[0]) begin
              t_d = mul_res;
            end else begin
              jr_we    = 1'b1;
              jr_widx  = 5'd9 + 5'(step_q[4:1]);
              jr_wdata = sat_add(t_q, mul_res, 1'b1);
            end
          end else if (step_q == 5'd20) begin
            det_d = det_sum;
            acc_d = '0;
            ca_d  = '0;
            cb_d  = '0;
            cn_d  = '0;
            if (det_sum == 64'sd0) begin
              sing_d  = 1'b1;
              rs_d    = '0;
              state_d = S_G_RDA;
            end else begin
              sing_d  = 1'b0;
              state_d = S_DIV;
            end
          end else begin
            acc_d = acc_sum;
          end
        end
      end
      S_DIV: state_d = S_DV_WT;
      S_DV_WT: begin
        if (dstat.done) begin
          rs_d    = det_q[63] ? (64'd0 - div_q) : div_q;
          state_d = S_G_RDA;
        end
      end
      S_G_RDA: begin
        if (sing_q) begin
          for (int i = 0; i < 3; i++) begin
            g_d[i] = '0;
          end
          state_d = S_OUT;
        end else begin
          state_d = S_G_WT;
        end
      end
      S_G_WT: begin
        if (mstat.done) begin
          acc_d = acc_sum;
          if (cb_q == 2'd2) begin
            state_d = S_G_FIN;
          end else begin
            cb_d    = cb_q + 2'd1;
            state_d = S_G_RDA;
          end
        end
      end
      S_G_FIN: state_d = S_G_FWT;
      S_G_FWT: begin
        if (mstat.done) begin
          g_d[ca_q] = sat_cw(mul_res);
          acc_d     = '0;
          cb_d      = '0;
          if (ca_q == 2'd2) begin
            state_d = S_OUT;
          end else begin
            ca_d    = ca_q + 2'd1;
            state_d = S_G_RDA;
          end
        end
      end
      S_OUT: begin
        // wait for the output register to free up
        if (out_load) begin
          ca_d = '0;
          cb_d = '0;
          if (cn_q == 3'd7) begin
            state_d = S_IDLE;
          end else begin
            cn_d    = cn_q + 3'd1;
            state_d = S_G_RDA;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ca_q        <= '0;
      cb_q        <= '0;
      cn_q        <= '0;
      step_q      <= '0;
      sing_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ca_q        <= ca_d;
      cb_q        <= cb_d;
      cn_q        <= cn_d;
      step_q      <= step_d;
      sing_q      <= sing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gp_q  <= gp_d;
    acc_q <= acc_d;
    t_q   <= t_d;
    opa_q <= opa_d;
    det_q <= det_d;
    rs_q  <= rs_d;
    g_q   <= g_d;
    if (in_i.valid && in_i.ready) begin
      cx_q[in_i.node_index] <= in_i.node_x;
      cy_q[in_i.node_index] <= in_i.node_y;
      cz_q[in_i.node_index] <= in_i.node_z;
    end
    if (jr_we) begin
      jr_q[jr_widx] <= jr_wdata;
    end
    if (out_load) begin
      o_node_q <= cn_q;
      o_gx_q   <= g_q[0];
      o_gy_q   <= g_q[1];
      o_gz_q   <= g_q[2];
      o_det_q  <= sat_cw(det_q);
      o_sing_q <= sing_q;
      o_last_q <= (cn_q == 3'd7);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_node     = o_node_q;
  assign out_o.grad_x       = o_gx_q;
  assign out_o.grad_y       = o_gy_q;
  assign out_o.grad_z       = o_gz_q;
  assign out_o.jacobian_det = o_det_q;
  assign out_o.point_weight = {1'b1, {FRAC_BITS{1'b0}}};
  assign out_o.singular     = o_sing_q;
  assign out_o.last         = o_last_q;

`ifndef SYNTHESIS
  a_ready_idle_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !mstat.busy && !dstat.busy)
    else $error("request taken while a shared unit is busy");

  a_mul_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.start |-> !mstat.busy)
    else $error("multiplier restarted while busy");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.singular) |->
      (out_o.grad_x == '0) && (out_o.grad_y == '0) && (out_o.grad_z == '0))
    else $error("singular result carries nonzero gradient");

  a_load_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (cn_q == 3'd7)) |=> in_i.ready)
    else $error("sequencer did not return to idle after node 7");
`endif

endmodule

/* test/tb_hex8_shape_gradient.sv */
// Self-checking testbench for hex8_shape_gradient: node requests in, eight gradient results out.
module tb_hex8_shape_gradient;
  import hsg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;
  localparam int RANDOM_ITEMS = 300;

  typedef struct {
    logic [2:0]  gp;
    logic [2:0]  node;
    logic [31:0] x, y, z;
    bit          has_exp;   // det and singular typed in by hand
    logic [31:0] exp_det;
    logic        exp_sing;
  } node_req_t;

  typedef struct {
    logic [2:0]  node;
    logic [31:0] gx, gy, gz, det;
    logic [16:0] wt;
    logic        sing, last;
  } grad_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hsg_in_if  #(.COORD_WIDTH(CW)) in_if ();
  hsg_out_if #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) out_if ();

  hex8_shape_gradient #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  node_req_t req_q[$];
  grad_res_t grad_q[$];
  logic signed [63:0] xs[8], ys[8], zs[8];
  int errors = 0;
  int idle_cycles = 0;
  bit send_done = 0;

  // ---------------- predictor ----------------
  function automatic logic signed [63:0] clamp65(input logic signed [64:0] v);
    if (v[64] != v[63]) return v[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] add_s(input logic signed [63:0] a, b);
    return clamp65({a[63], a} + {b[63], b});
  endfunction

  function automatic logic signed [63:0] sub_s(input logic signed [63:0] a, b);
    return clamp65({a[63], a} - {b[63], b});
  endfunction

  // full product, floor shift, saturate to 64 bits
  function automatic logic signed [63:0] mul_shr(input logic signed [63:0] a, b, input int s);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = (pa * pb) >>> s;
    if (p[127:63] != {65{p[63]}}) return p[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] cross_q(input logic signed [63:0] a, b, c, d);
    return sub_s(mul_shr(a, b, FB), mul_shr(c, d, FB));
  endfunction

  function automatic logic [31:0] narrow(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic bit plus_side(input logic [2:0] i, input int d);
    if (d == 0) return i[0] ^ i[1];
    if (d == 1) return i[1];
    return i[2];
  endfunction

  // Store the node, and on node 7 queue the eight gradients of the element.
  function automatic void load_and_predict(input node_req_t r);
    logic [63:0] ap, am;
    logic signed [63:0] mag[3], dp[3][8], jac[3][3], adj[3][3], det, rs, num, g;
    logic signed [63:0] cs[3][8];
    logic [63:0] ud;
    grad_res_t res;
    int cnt;
    bit sing;
    xs[r.node] = $signed(r.x);
    ys[r.node] = $signed(r.y);
    zs[r.node] = $signed(r.z);
    if (r.node != 3'd7) return;
    ap = 64'd1073741824 + 64'd619925131;
    am = 64'd1073741824 - 64'd619925131;
    mag[2] = (ap * ap) >> 33;
    mag[1] = (ap * am) >> 33;
    mag[0] = (am * am) >> 33;
    for (int b = 0; b < 3; b++)
      for (int n = 0; n < 8; n++) begin
        cnt = 0;
        for (int k = 0; k < 3; k++)
          if (k != b && plus_side(3'(n), k) == plus_side(r.gp, k)) cnt++;
        dp[b][n] = plus_side(3'(n), b) ? mag[cnt] : -mag[cnt];
      end
    for (int n = 0; n < 8; n++) begin
      cs[0][n] = xs[n];
      cs[1][n] = ys[n];
      cs[2][n] = zs[n];
    end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) begin
        jac[a][b] = 0;
        for (int n = 0; n < 8; n++) jac[a][b] = add_s(jac[a][b], mul_shr(cs[a][n], dp[b][n], 30));
      end
    adj[0][0] = cross_q(jac[1][1], jac[2][2], jac[1][2], jac[2][1]);
    adj[0][1] = cross_q(jac[0][2], jac[2][1], jac[0][1], jac[2][2]);
    adj[0][2] = cross_q(jac[0][1], jac[1][2], jac[0][2], jac[1][1]);
    adj[1][0] = cross_q(jac[1][2], jac[2][0], jac[1][0], jac[2][2]);
    adj[1][1] = cross_q(jac[0][0], jac[2][2], jac[0][2], jac[2][0]);
    adj[1][2] = cross_q(jac[0][2], jac[1][0], jac[0][0], jac[1][2]);
    adj[2][0] = cross_q(jac[1][0], jac[2][1], jac[1][1], jac[2][0]);
    adj[2][1] = cross_q(jac[0][1], jac[2][0], jac[0][0], jac[2][1]);
    adj[2][2] = cross_q(jac[0][0], jac[1][1], jac[0][1], jac[1][0]);
    det = add_s(add_s(mul_shr(jac[0][0], adj[0][0], FB), mul_shr(jac[0][1], adj[1][0], FB)),
                mul_shr(jac[0][2], adj[2][0], FB));
    sing = (det == 0);
    rs = 0;
    if (!sing) begin
      ud = det[63] ? (64'd0 - det) : det;
      rs = (64'd1 << 62) / ud;
      if (det[63]) rs = -rs;
    end
    for (int n = 0; n < 8; n++) begin
      logic [31:0] gv[3];
      for (int a = 0; a < 3; a++) begin
        num = 0;
        g = 0;
        if (!sing) begin
          for (int k = 0; k < 3; k++) num = add_s(num, mul_shr(adj[k][a], dp[k][n], 30));
          g = mul_shr(num, rs, 62 - FB);
        end
        gv[a] = narrow(g);
      end
      res.node = 3'(n);
      res.gx = gv[0];
      res.gy = gv[1];
      res.gz = gv[2];
      res.det = r.has_exp ? r.exp_det : narrow(det);
      res.wt = 17'd1 << FB;
      res.sing = r.has_exp ? r.exp_sing : sing;
      res.last = (n == 7);
      grad_q.push_back(res);
    end
  endfunction

  // ---------------- stimulus ----------------
  function automatic void add_req(input logic [2:0] gp, node, input logic [31:0] x, y, z,
                                  input bit he = 0, input logic [31:0] ed = 0,
                                  input logic es = 0);
    node_req_t r;
    r.gp = gp; r.node = node; r.x = x; r.y = y; r.z = z;
    r.has_exp = he; r.exp_det = ed; r.exp_sing = es;
    req_q.push_back(r);
  endfunction

  function automatic logic [31:0] corner(input logic [2:0] n, input int d, input int s, j);
    int v;
    v = plus_side(n, d) ? s : -s;
    if (j > 0) v += $signed($urandom_range(0, 2 * j)) - j;
    return v;
  endfunction

  function automatic void build_stimulus();
    logic [2:0] order[8];
    logic [2:0] tmp;
    int s, j, pick, k;
    // cube [-1,1]^3: J near identity, floored derivatives keep det a few units under 1.0
    for (int n = 0; n < 8; n++)
      add_req(3'(n), 3'(n), corner(3'(n), 0, 65536, 0), corner(3'(n), 1, 65536, 0),
              corner(3'(n), 2, 65536, 0));
    // collapsed element: det 0, singular
    for (int n = 0; n < 8; n++)
      add_req(3'd7 - 3'(n), 3'(n), 0, 0, 0, n == 7, 32'd0, 1'b1);
    // coordinate extremes, saturating sums
    add_req(3'd0, 3'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    add_req(3'd1, 3'd2, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    add_req(3'd2, 3'd5, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_req(3'd3, 3'd7, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    // repeated node overwrites; gauss point of node 7 selects
    add_req(3'd0, 3'd3, 32'h0, 32'h0, 32'h0);
    for (int n = 0; n < 8; n++)
      add_req(3'(n) ^ 3'd5, 3'(n), corner(3'(n), 0, 40000, 3000),
              corner(3'(n), 1, 70000, 3000), corner(3'(n), 2, 9000, 500));

    while (req_q.size() < RANDOM_ITEMS + 29) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        // well-formed element, shuffled load order
        for (int n = 0; n < 8; n++) order[n] = 3'(n);
        for (int n = 6; n > 0; n--) begin
          k = $urandom_range(0, n);
          tmp = order[n]; order[n] = order[k]; order[k] = tmp;
        end
        s = $urandom_range(1 << 8, 1 << 20);
        j = s / 4;
        for (int n = 0; n < 8; n++)
          add_req(3'($urandom), order[n], corner(order[n], 0, s, j),
                  corner(order[n], 1, $urandom_range(1 << 8, 1 << 20), j),
                  corner(order[n], 2, s, j));
      end else if (pick <= 7) begin
        for (int n = 0; n < 8; n++) add_req(3'($urandom), 3'(n), $urandom, $urandom, $urandom);
      end else if (pick == 8) begin
        // touch a few nodes, then recompute on what is stored
        repeat ($urandom_range(0, 3))
          add_req(3'($urandom), 3'($urandom_range(0, 6)), $urandom, $urandom, $urandom);
        add_req(3'($urandom), 3'd7, $urandom, $urandom, $urandom);
      end else if ($urandom_range(0, 1) == 0) begin
        for (int n = 0; n < 8; n++) add_req(3'($urandom), 3'(n), 0, 0, 0);
      end else begin
        // flat element: all z equal
        s = $urandom;
        for (int n = 0; n < 8; n++)
          add_req(3'($urandom), 3'(n), $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20), s);
      end
    end
  endfunction

  // ---------------- request driver ----------------
  initial begin
    int gap;
    node_req_t r;
    in_if.valid = 1'b0;
    in_if.gauss_point = '0;
    in_if.node_index = '0;
    in_if.node_x = '0;
    in_if.node_y = '0;
    in_if.node_z = '0;
    build_stimulus();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (req_q.size() > 0) begin
      r = req_q.pop_front();
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_if.valid <= 1'b1;
      in_if.gauss_point <= r.gp;
      in_if.node_index <= r.node;
      in_if.node_x <= r.x;
      in_if.node_y <= r.y;
      in_if.node_z <= r.z;
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);
      load_and_predict(r);
    end
    in_if.valid <= 1'b0;
    send_done = 1;
  end

  // ---------------- result receiver and checker ----------------
  initial begin
    int gap;
    int rx_count;
    grad_res_t e;
    rx_count = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (rx_count == 40) gap = LONG_HOLD;   // back up the block into its input
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      rx_count++;
      if (grad_q.size() == 0) begin
        $display("%0t: unexpected result node %0d", $time, out_if.out_node);
        errors++;
      end else begin
        e = grad_q.pop_front();
        if ({out_if.out_node, out_if.grad_x, out_if.grad_y, out_if.grad_z, out_if.jacobian_det,
             out_if.point_weight, out_if.singular, out_if.last} !==
            {e.node, e.gx, e.gy, e.gz, e.det, e.wt, e.sing, e.last}) begin
          $display("%0t: mismatch exp node=%0d gx=%h gy=%h gz=%h det=%h wt=%h sing=%b last=%b",
                   $time, e.node, e.gx, e.gy, e.gz, e.det, e.wt, e.sing, e.last);
          $display("%0t:          got node=%0d gx=%h gy=%h gz=%h det=%h wt=%h sing=%b last=%b",
                   $time, out_if.out_node, out_if.grad_x, out_if.grad_y, out_if.grad_z,
                   out_if.jacobian_det, out_if.point_weight, out_if.singular, out_if.last);
          errors++;
        end
      end
    end
  end

  // ---------------- watchdog and end of run ----------------
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_hex8_shape_gradient: errors");
      $finish;
    end
  end

  initial begin
    wait (send_done && grad_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_hex8_shape_gradient: clean");
    end else begin
      $display("tb_hex8_shape_gradient: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/hsg_pkg.sv
rtl/core/hsg_if.sv
rtl/core/hsg_mul.sv
rtl/core/hsg_div.sv
rtl/core/hex8_shape_gradient.sv
test/tb_hex8_shape_gradient.sv
